// ===== rtl/c8f_pkg.sv =====
package c8f_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

  localparam int NUM_REGS = 16;
  localparam int REG_AW   = 4;
  localparam int REG_W    = 8;
  localparam int PC_W     = 12;
  localparam int OP_W     = 16;

  localparam logic [3:0] GRP_SYS    = 4'h0;
  localparam logic [3:0] GRP_JP     = 4'h1;
  localparam logic [3:0] GRP_CALL   = 4'h2;
  localparam logic [3:0] GRP_SE     = 4'h3;
  localparam logic [3:0] GRP_SNE    = 4'h4;
  localparam logic [3:0] GRP_SE_REG = 4'h5;
  localparam logic [3:0] GRP_LD     = 4'h6;
  localparam logic [3:0] GRP_ADD    = 4'h7;

  localparam logic [OP_W-1:0] OP_CLS = 16'h00E0;
  localparam logic [OP_W-1:0] OP_RET = 16'h00EE;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OVER   = 2'd1,
    ST_UNDER  = 2'd2,
    ST_UNIMPL = 2'd3
  } status_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [REG_W-1:0]  data;
  } rf_wr_t;

endpackage

// ===== rtl/c8f_regfile.sv =====
module c8f_regfile import c8f_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [REG_AW-1:0] rd_x_addr,
  input  logic [REG_AW-1:0] rd_y_addr,
  input  rf_wr_t            wr,
  output logic [REG_W-1:0]  x_data,
  output logic [REG_W-1:0]  y_data
);

  logic [REG_W-1:0]  mem [NUM_REGS];
  logic              vld_r [NUM_REGS];
  logic [REG_W-1:0]  rd_x_r, rd_y_r;
  logic [REG_AW-1:0] rd_x_addr_r, rd_y_addr_r;
  rf_wr_t            wb_r;

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x_r      <= vld_r[rd_x_addr] ? mem[rd_x_addr] : '0;
      rd_y_r      <= vld_r[rd_y_addr] ? mem[rd_y_addr] : '0;
      rd_x_addr_r <= rd_x_addr;
      rd_y_addr_r <= rd_y_addr;
    end
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        vld_r[i] <= 1'b0;
      end
      wb_r.en <= 1'b0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
      wb_r           <= wr;
    end
  end

  // the latest write wins over a read that saw the old contents
  assign x_data = (wb_r.en && wb_r.addr == rd_x_addr_r) ? wb_r.data : rd_x_r;
  assign y_data = (wb_r.en && wb_r.addr == rd_y_addr_r) ? wb_r.data : rd_y_r;

endmodule

// ===== rtl/chip8_flow_and_register_ops.sv =====
// Execute stage for CHIP-8 opcode groups 0 to 7.
// Input channel: in_instruction with in_pc_now (already advanced past the
// opcode); a transfer happens when in_valid is high and in_stall is low.
// Result channel: out_next_pc, out_clear_screen, out_vx_value, out_status;
// a transfer happens when out_valid is high and out_stall is low.
// The instruction is held in the execute stage register and its result
// then in the output register, which drives out_valid. One instruction
// is taken every cycle while the receiver does not stall; the register
// file and return stack memories are read in the transfer cycle and
// written back as the instruction leaves execute, with the last write
// forwarded to a read of the same entry. While the receiver stalls,
// the output register holds its result. An empty execute stage still
// takes one more; when both are full, in_stall equals out_stall.
// Reset clears the sixteen data registers (through valid bits) and empties
// the return stack; no clearing pass is needed, the block takes input in
// the first cycle after reset.
module chip8_flow_and_register_ops import c8f_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] in_instruction,
  input  logic [PC_W-1:0] in_pc_now,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PC_W-1:0] out_next_pc,
  output logic            out_clear_screen,
  output logic [REG_W-1:0] out_vx_value,
  output logic [1:0]      out_status
);

  // handshake
  logic accept, out_free, s1_adv;

  // execute stage
  logic             s1_valid_r;
  logic [OP_W-1:0]  s1_op_r;
  logic [PC_W-1:0]  s1_pc_r;

  // register file
  rf_wr_t           rf_wr;
  logic [REG_W-1:0] x_data, y_data;

  // return stack
  logic [PC_W-1:0]  stk_mem [STACK_DEPTH];
  logic [PC_W-1:0]  stk_rd_r;
  logic [SP_W-1:0]  stk_rd_addr_r;
  logic             stk_wb_vld_r;
  logic [SP_W-1:0]  stk_wb_addr_r;
  logic [PC_W-1:0]  stk_wb_data_r;
  logic [PC_W-1:0]  stk_data;
  logic [LVL_W-1:0] lvl_r, lvl_nxt, lvl_eff, lvl_dec;
  logic [SP_W-1:0]  stk_rd_addr;
  logic             push;

  // result computation
  logic [3:0]       grp;
  logic [PC_W-1:0]  skip_pc;
  logic [PC_W-1:0]  next_pc;
  logic             clr;
  status_t          status;
  logic [REG_W-1:0] vx_new;

  // output register
  logic             out_valid_r;
  logic [PC_W-1:0]  out_next_pc_r;
  logic             out_clear_r;
  logic [REG_W-1:0] out_vx_r;
  status_t          out_status_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  c8f_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_x_addr (in_instruction[11:8]),
    .rd_y_addr (in_instruction[7:4]),
    .wr        (rf_wr),
    .x_data    (x_data),
    .y_data    (y_data)
  );

  // stack pointer seen by the incoming instruction includes the
  // update of the instruction that leaves execute in this cycle
  assign lvl_eff     = s1_adv ? lvl_nxt : lvl_r;
  assign lvl_dec     = lvl_eff - LVL_W'(1);
  assign stk_rd_addr = lvl_dec[SP_W-1:0];

  always_ff @(posedge clk) begin
    if (accept && lvl_eff != '0) begin
      stk_rd_r <= stk_mem[stk_rd_addr];
    end
    if (accept) begin
      stk_rd_addr_r <= stk_rd_addr;
    end
    if (s1_adv && push) begin
      stk_mem[lvl_r[SP_W-1:0]] <= s1_pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_wb_vld_r <= 1'b0;
    end else if (s1_adv && push) begin
      stk_wb_vld_r  <= 1'b1;
      stk_wb_addr_r <= lvl_r[SP_W-1:0];
      stk_wb_data_r <= s1_pc_r;
    end
  end

  // forward a push that landed in the same cycle as the read
  assign stk_data = (stk_wb_vld_r && stk_wb_addr_r == stk_rd_addr_r) ?
                    stk_wb_data_r : stk_rd_r;

  // decode and execute
  assign grp     = s1_op_r[15:12];
  assign skip_pc = s1_pc_r + PC_W'(2);

  always_comb begin
    next_pc = s1_pc_r;
    clr     = 1'b0;
    status  = ST_OK;
    vx_new  = x_data;
    rf_wr.en   = 1'b0;
    rf_wr.addr = s1_op_r[11:8];
    rf_wr.data = '0;
    push    = 1'b0;
    lvl_nxt = lvl_r;
    case (grp)
      GRP_SYS: begin
        if (s1_op_r == OP_CLS) begin
          clr = 1'b1;
        end else if (s1_op_r == OP_RET) begin
          if (lvl_r == '0) begin
            status = ST_UNDER;
          end else begin
            next_pc = stk_data;
            lvl_nxt = lvl_r - LVL_W'(1);
          end
        end else begin
          status = ST_UNIMPL;
        end
      end
      GRP_JP: begin
        next_pc = s1_op_r[11:0];
      end
      GRP_CALL: begin
        if (lvl_r == LVL_W'(STACK_DEPTH)) begin
          status = ST_OVER;
        end else begin
          push    = 1'b1;
          next_pc = s1_op_r[11:0];
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      GRP_SE: begin
        if (x_data == s1_op_r[7:0]) next_pc = skip_pc;
      end
      GRP_SNE: begin
        if (x_data != s1_op_r[7:0]) next_pc = skip_pc;
      end
      GRP_SE_REG: begin
        if (x_data == y_data) next_pc = skip_pc;
      end
      GRP_LD: begin
        vx_new   = s1_op_r[7:0];
        rf_wr.en = s1_adv;
      end
      GRP_ADD: begin
        vx_new   = x_data + s1_op_r[7:0];
        rf_wr.en = s1_adv;
      end
      default: begin
        status = ST_UNIMPL;
      end
    endcase
    rf_wr.data = vx_new;
  end

  // execute stage: load on transfer, drop when the result moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      lvl_r      <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        lvl_r <= lvl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r <= in_instruction;
      s1_pc_r <= in_pc_now;
    end
  end

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_next_pc_r <= next_pc;
      out_clear_r   <= clr;
      out_vx_r      <= vx_new;
      out_status_r  <= status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_next_pc_r;
  assign out_clear_screen = out_clear_r;
  assign out_vx_value     = out_vx_r;
  assign out_status       = out_status_r;

endmodule
